@@ sv/gfrma_pkg.sv @@
// Shared types and constants for the GF(16) region multiply-add unit.
`default_nettype none
package gfrma_pkg;
   localparam int NIB_W       = 4;
   localparam int MAX_NIBBLES = 16;
   localparam int WORD_W      = NIB_W * MAX_NIBBLES;
   localparam int POLY_W      = 5;
   localparam logic [POLY_W-1:0] POLY_RESET = 5'd19;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_MUL  = 2'd1,
      OP_MADD = 2'd2,
      OP_PASS = 2'd3
   } opcode_type;

   typedef logic [NIB_W-1:0] nibble_type;

   typedef struct packed {
      opcode_type                 op;
      logic [WORD_W-1:0]          dest;
      logic [WORD_W-1:0]          operand;
      nibble_type [NIB_W-1:0]     mult;
      logic                       last;
   } expand_type;

   typedef struct packed {
      opcode_type        op;
      logic [WORD_W-1:0] dest;
      logic [WORD_W-1:0] operand;
      logic [WORD_W-1:0] prod;
      logic              last;
   } product_type;

   function automatic nibble_type times_x(nibble_type a, nibble_type taps);
      nibble_type r;
      r = {a[NIB_W-2:0], 1'b0};
      if (a[NIB_W-1]) begin
         r = r ^ taps;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

@@ sv/gfrma_coef_expand.sv @@
// First stage: coefficient times powers of x, operand selection.
`default_nettype none
module gfrma_coef_expand (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_ready,
   input  wire gfrma_pkg::opcode_type                 in_op,
   input  wire logic [gfrma_pkg::WORD_W-1:0]          in_dest,
   input  wire logic [gfrma_pkg::WORD_W-1:0]          in_src,
   input  wire gfrma_pkg::nibble_type                 in_coef,
   input  wire logic                                  in_last,
   input  wire logic [gfrma_pkg::POLY_W-1:0]          poly,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output gfrma_pkg::expand_type                      out_item
);
   import gfrma_pkg::*;

   logic       valid_ff;
   expand_type item_ff;
   expand_type item_in;
   nibble_type taps;

   assign taps = poly[NIB_W-1:0];
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in.op      = in_op;
      item_in.dest    = in_dest;
      item_in.operand = (in_op == OP_MUL) ? in_dest : in_src;
      item_in.last    = in_last;
      item_in.mult[0] = in_coef;
      for (int k = 1; k < NIB_W; k++) begin
         item_in.mult[k] = times_x(item_in.mult[k-1], taps);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

@@ sv/gfrma_nibble_mul.sv @@
// Second stage: per-nibble carry-less product from the expanded coefficient.
`default_nettype none
module gfrma_nibble_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire gfrma_pkg::expand_type in_item,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output gfrma_pkg::product_type     out_item
);
   import gfrma_pkg::*;

   logic        valid_ff;
   product_type item_ff;
   product_type item_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      item_in.op      = in_item.op;
      item_in.dest    = in_item.dest;
      item_in.operand = in_item.operand;
      item_in.last    = in_item.last;
      item_in.prod    = '0;
      for (int i = 0; i < MAX_NIBBLES; i++) begin
         for (int k = 0; k < NIB_W; k++) begin
            if (in_item.operand[i*NIB_W+k]) begin
               item_in.prod[i*NIB_W +: NIB_W] =
                  item_in.prod[i*NIB_W +: NIB_W] ^ in_item.mult[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

@@ sv/gf16_region_multiply_add_unit.sv @@
// Top level of the GF(16) region multiply-add unit with output stage.
// Takes one word item per cycle and returns its result through
// a three-stage pipeline: coefficient expansion, nibble products, result select.
// Throughput is one item per cycle whenever rsp_tready is high; a stall holds every
// full stage. Write the polynomial on the csr port only while no item is in flight.
`default_nettype none
module gf16_region_multiply_add_unit #(
   parameter int WORD_NIBBLES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode[1:0], dest_word[65:2], src_word[129:66], coefficient[133:130], zero[135:134]
   input  wire logic [135:0] req_tdata,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_word[63:0]
   output logic [63:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [4:0]   csr_wdata
);
   import gfrma_pkg::*;

   logic [POLY_W-1:0] poly_ff;
   logic              exp_valid;
   logic              exp_ready;
   expand_type        exp_item;
   logic              mul_valid;
   logic              mul_ready;
   product_type       mul_item;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic [WORD_W-1:0] rsp_data_in;
   logic              rsp_last_ff;
   logic [WORD_W-1:0] nibble_mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
      end else if (csr_valid) begin
         poly_ff <= csr_wdata;
      end
   end

   gfrma_coef_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (opcode_type'(req_tdata[1:0])),
      .in_dest   (req_tdata[65:2]),
      .in_src    (req_tdata[129:66]),
      .in_coef   (req_tdata[133:130]),
      .in_last   (req_tlast),
      .poly      (poly_ff),
      .out_valid (exp_valid),
      .out_ready (exp_ready),
      .out_item  (exp_item)
   );

   gfrma_nibble_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exp_valid),
      .in_ready  (exp_ready),
      .in_item   (exp_item),
      .out_valid (mul_valid),
      .out_ready (mul_ready),
      .out_item  (mul_item)
   );

   assign mul_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      for (int i = 0; i < MAX_NIBBLES; i++) begin
         nibble_mask[i*NIB_W +: NIB_W] = (i < WORD_NIBBLES) ? '1 : '0;
      end
      case (mul_item.op)
         OP_ADD:  rsp_data_in = mul_item.dest ^ mul_item.operand;
         OP_MUL:  rsp_data_in = mul_item.prod;
         OP_MADD: rsp_data_in = mul_item.dest ^ mul_item.prod;
         default: rsp_data_in = mul_item.dest;
      endcase
      rsp_data_in = rsp_data_in & nibble_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         rsp_valid_ff <= mul_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && mul_valid) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= mul_item.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> poly_ff == $past(csr_wdata))
      else $error("polynomial register not updated");
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata & ~nibble_mask) == '0)
      else $error("unused nibbles not zero");
endmodule
`default_nettype wire

@@ verif/tb_gf16_region_multiply_add_unit.sv @@
// Self-checking testbench for the GF(16) region multiply-add unit.
module tb_gf16_region_multiply_add_unit;
   import gfrma_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 225;

   class region_result_checker;
      typedef struct {
         logic [WORD_W-1:0] word;
         logic              last;
      } word_result_type;

      logic [POLY_W-1:0] poly;
      word_result_type   pending_words[$];
      int                errors;

      function new();
         poly   = POLY_RESET;
         errors = 0;
      endfunction

      function automatic nibble_type field_mul(nibble_type a, nibble_type b);
         nibble_type acc;
         logic       carry;
         acc = '0;
         for (int k = 0; k < NIB_W; k++) begin
            if (b[k]) begin
               acc = acc ^ a;
            end
            carry = a[NIB_W-1];
            a = {a[NIB_W-2:0], 1'b0};
            if (carry) begin
               a = a ^ poly[NIB_W-1:0];
            end
         end
         return acc;
      endfunction

      function automatic logic [WORD_W-1:0] predict_word(opcode_type op,
            logic [WORD_W-1:0] dest, logic [WORD_W-1:0] src, nibble_type coef);
         logic [WORD_W-1:0] word;
         nibble_type        d;
         nibble_type        s;
         nibble_type        r;
         word = '0;
         for (int i = 0; i < MAX_NIBBLES; i++) begin
            d = dest[NIB_W*i +: NIB_W];
            s = src[NIB_W*i +: NIB_W];
            case (op)
               OP_ADD:  r = d ^ s;
               OP_MUL:  r = field_mul(coef, d);
               OP_MADD: r = d ^ field_mul(coef, s);
               default: r = d;
            endcase
            word[NIB_W*i +: NIB_W] = r;
         end
         return word;
      endfunction

      function void note_item(opcode_type op, logic [WORD_W-1:0] dest,
            logic [WORD_W-1:0] src, nibble_type coef, logic last);
         word_result_type res;
         res.word = predict_word(op, dest, src, coef);
         res.last = last;
         pending_words.push_back(res);
      endfunction

      task report(string msg);
         if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
         errors++;
      endtask

      task check_result(logic [WORD_W-1:0] word, logic last);
         word_result_type want;
         if (pending_words.size() == 0) begin
            report($sformatf("unexpected item word=%h last=%b", word, last));
         end else begin
            want = pending_words.pop_front();
            if (word !== want.word) begin
               report($sformatf("result_word %h, want %h", word, want.word));
            end
            if (last !== want.last) begin
               report($sformatf("last_out %b, want %b", last, want.last));
            end
         end
      endtask

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata  = '0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_wdata  = '0;

   region_result_checker board = new();

   int  idle_pct   = 25;
   bit  tail_quiet = 1'b0;
   int  hold_left  = 0;
   int  quiet_cycles = 0;

   gf16_region_multiply_add_unit #(
      .WORD_NIBBLES(MAX_NIBBLES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
         rsp_tready <= 1'b0;
         hold_left  <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic pause_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_item(opcode_type op, logic [WORD_W-1:0] dest,
         logic [WORD_W-1:0] src, nibble_type coef, logic last);
      if (!tail_quiet && $urandom_range(0, 99) < idle_pct) begin
         pause_sender($urandom_range(1, 12));
      end
      req_tdata  <= {2'b00, coef, src, dest, op};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_item(op, dest, src, coef, last);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_poly(logic [POLY_W-1:0] value);
      drain_results();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.poly = value;
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic run_directed();
      logic [WORD_W-1:0] ramp;
      logic [WORD_W-1:0] down;
      ramp = 64'hfedcba9876543210;
      down = 64'h0123456789abcdef;
      send_item(OP_ADD,  '0,   '0,   4'h0, 1'b0);
      send_item(OP_ADD,  '1,   '1,   4'hf, 1'b1);
      send_item(OP_ADD,  '1,   '0,   4'h0, 1'b0);
      send_item(OP_ADD,  ramp, down, 4'h5, 1'b1);
      send_item(OP_MUL,  ramp, '1,   4'h0, 1'b0);
      send_item(OP_MUL,  ramp, '0,   4'h1, 1'b0);
      send_item(OP_MUL,  ramp, down, 4'hf, 1'b1);
      send_item(OP_MUL,  ramp, down, 4'h2, 1'b0);
      send_item(OP_MUL,  '1,   '0,   4'h9, 1'b0);
      send_item(OP_MUL,  '0,   '1,   4'hf, 1'b1);
      send_item(OP_MADD, ramp, down, 4'h0, 1'b0);
      send_item(OP_MADD, ramp, down, 4'h1, 1'b0);
      send_item(OP_MADD, '0,   ramp, 4'hf, 1'b1);
      send_item(OP_MADD, '1,   ramp, 4'h7, 1'b0);
      send_item(OP_MADD, '1,   '1,   4'hf, 1'b1);
      send_item(OP_PASS, '1,   '1,   4'hf, 1'b1);
      send_item(OP_PASS, ramp, '0,   4'h0, 1'b0);
      send_item(OP_PASS, '0,   '1,   4'ha, 1'b1);
   endtask

   task automatic run_random(int count);
      opcode_type op;
      for (int n = 0; n < count; n++) begin
         op = opcode_type'($urandom_range(0, 3));
         send_item(op, random_word(), random_word(), nibble_type'($urandom_range(0, 15)),
                   ($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      logic [POLY_W-1:0] polys [6];
      polys = '{5'd31, 5'd16, 5'd3, 5'd25, 5'd0, 5'd19};
      polys[5] = $urandom_range(16, 31);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(PHASE_ITEMS / 2);
      for (int p = 0; p < 6; p++) begin
         write_poly(polys[p]);
         idle_pct = (p == 3) ? 0 : 25;
         tail_quiet = (p == 5);
         if (p == 2) begin
            run_directed();
         end
         run_random(PHASE_ITEMS - ((p == 2) ? 18 : 0) - ((p == 0) ? PHASE_ITEMS / 2 : 0));
      end
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.pending() != 0) begin
         board.report($sformatf("%0d results never arrived", board.pending()));
      end
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
